@@ rtl/cubic_bezier_easing_top_assert.svh @@
// Assertion macros shared by the easing curve RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CUBIC_BEZIER_EASING_TOP_ASSERT_SVH
`define CUBIC_BEZIER_EASING_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CBE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cbe_pkg.sv @@
// Types and fixed point constants for the cubic Bezier easing pipeline.
// No dependencies; used by cbe_newton and cubic_bezier_easing_top.
package cbe_pkg;

   localparam int FRAC_BITS = 16;
   localparam int S_W       = 17;
   localparam int CX_W      = 17;
   localparam int CY_W      = 19;
   localparam int F0_W      = 20;
   localparam int F1_W      = 21;
   localparam int F2_W      = 20;
   localparam int D_W       = 23;
   localparam int X_W       = 23;
   localparam int DM_W      = 22;
   localparam int Q_W       = 18;
   localparam int REM_W     = DM_W + Q_W;

   localparam logic [S_W-1:0] ONE_FX = S_W'(1 << FRAC_BITS);

   typedef struct packed {
      logic signed [F0_W-1:0] f0;
      logic signed [F1_W-1:0] f1;
      logic signed [F2_W-1:0] f2;
   } coef_type;

endpackage

@@ rtl/cbe_newton.sv @@
// One Newton step of the curve parameter search, fully pipelined.
// Depends on cbe_pkg; instantiated once per step by cubic_bezier_easing_top.
module cbe_newton import cbe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  coef_type       coef,
   input  logic           in_valid,
   input  logic [S_W-1:0] in_s,
   input  logic [S_W-1:0] in_t,
   output logic           out_valid,
   output logic [S_W-1:0] out_s,
   output logic [S_W-1:0] out_t
);

   // stage 1: s^2, f1*s, f2*s
   logic                   v1_ff;
   logic [S_W-1:0]         s1_ff, t1_ff, s2_1_ff, s2_1_in;
   logic signed [F1_W-1:0] f1s_1_ff, f1s_1_in;
   logic signed [F2_W-1:0] f2s_1_ff, f2s_1_in;
   logic [2*S_W-1:0]       sq1;
   logic signed [F1_W+S_W:0] pf1s;
   logic signed [F2_W+S_W:0] pf2s;

   // stage 2: s^3, f0*s^2, f1*s^2
   logic                   v2_ff;
   logic [S_W-1:0]         s_2_ff, t_2_ff, s3_2_ff, s3_2_in;
   logic signed [F0_W-1:0] f0s2_2_ff, f0s2_2_in;
   logic signed [F1_W-1:0] f1s2_2_ff, f1s2_2_in, f1s_2_ff;
   logic signed [F2_W-1:0] f2s_2_ff;
   logic [2*S_W-1:0]       sq2;
   logic signed [F0_W+S_W:0] pf0s2;
   logic signed [F1_W+S_W:0] pf1s2;

   // stage 3: f0*s^3 and the derivative
   logic                   v3_ff;
   logic [S_W-1:0]         s_3_ff, t_3_ff;
   logic signed [F0_W-1:0] f0s3_3_ff, f0s3_3_in;
   logic signed [F1_W-1:0] f1s2_3_ff;
   logic signed [F2_W-1:0] f2s_3_ff;
   logic signed [D_W-1:0]  d_3_ff, d_3_in;
   logic signed [F0_W+S_W:0] pf0s3;
   logic signed [D_W-1:0]  f0e, f1e, f2e;

   // stage 4: residual, magnitudes and quotient sign
   logic                   v4_ff, neg_4_ff, neg_4_in, dz_4_ff, dz_4_in;
   logic [S_W-1:0]         s_4_ff, t_4_ff;
   logic [DM_W-1:0]        xm_4_ff, xm_4_in, dm_4_ff, dm_4_in;
   logic signed [X_W-1:0]  diff;

   // divider stages, one quotient bit each, most significant first
   logic                   dv_v_ff   [Q_W];
   logic                   dv_neg_ff [Q_W];
   logic                   dv_dz_ff  [Q_W];
   logic [S_W-1:0]         dv_s_ff   [Q_W];
   logic [S_W-1:0]         dv_t_ff   [Q_W];
   logic [DM_W-1:0]        dv_dm_ff  [Q_W];
   logic [REM_W-1:0]       dv_rem_ff [Q_W];
   logic [REM_W-1:0]       dv_rem_in [Q_W];
   logic [Q_W-1:0]         dv_q_ff   [Q_W];
   logic [Q_W-1:0]         dv_q_in   [Q_W];

   // update stage
   logic                   v5_ff;
   logic [S_W-1:0]         s5_ff, t5_ff, s5_in;
   logic signed [S_W+1:0]  snew;
   logic [S_W-1:0]         qv;

   always_comb begin
      sq1      = in_s * in_s;
      pf1s     = coef.f1 * $signed({1'b0, in_s});
      pf2s     = coef.f2 * $signed({1'b0, in_s});
      s2_1_in  = sq1[FRAC_BITS +: S_W];
      f1s_1_in = pf1s[FRAC_BITS +: F1_W];
      f2s_1_in = pf2s[FRAC_BITS +: F2_W];

      sq2       = s2_1_ff * s1_ff;
      pf0s2     = coef.f0 * $signed({1'b0, s2_1_ff});
      pf1s2     = coef.f1 * $signed({1'b0, s2_1_ff});
      s3_2_in   = sq2[FRAC_BITS +: S_W];
      f0s2_2_in = pf0s2[FRAC_BITS +: F0_W];
      f1s2_2_in = pf1s2[FRAC_BITS +: F1_W];

      pf0s3     = coef.f0 * $signed({1'b0, s3_2_ff});
      f0s3_3_in = pf0s3[FRAC_BITS +: F0_W];
      f0e       = D_W'(f0s2_2_ff);
      f1e       = D_W'(f1s_2_ff);
      f2e       = D_W'(coef.f2);
      d_3_in    = (f0e <<< 1) + f0e + (f1e <<< 1) + f2e;

      diff     = X_W'(f0s3_3_ff) + X_W'(f1s2_3_ff) + X_W'(f2s_3_ff)
               - X_W'($signed({1'b0, t_3_ff}));
      xm_4_in  = diff[X_W-1] ? DM_W'(-diff) : DM_W'(diff);
      dm_4_in  = d_3_ff[D_W-1] ? DM_W'(-d_3_ff) : DM_W'(d_3_ff);
      neg_4_in = diff[X_W-1] ^ d_3_ff[D_W-1];
      dz_4_in  = (d_3_ff == '0);
   end

   // Restoring division on magnitudes. The top quotient bit only flags a
   // quotient large enough to push s past either clamp.
   always_comb begin
      logic [REM_W-1:0] prev_rem;
      logic [Q_W-1:0]   prev_q;
      logic [DM_W-1:0]  prev_dm;
      logic [REM_W-1:0] dsh;
      for (int j = 0; j < Q_W; j++) begin
         if (j == 0) begin
            prev_rem = REM_W'({xm_4_ff, {FRAC_BITS{1'b0}}});
            prev_q   = '0;
            prev_dm  = dm_4_ff;
         end else begin
            prev_rem = dv_rem_ff[j-1];
            prev_q   = dv_q_ff[j-1];
            prev_dm  = dv_dm_ff[j-1];
         end
         dsh = REM_W'(prev_dm) << (Q_W - 1 - j);
         if (prev_rem >= dsh) begin
            dv_rem_in[j] = prev_rem - dsh;
            dv_q_in[j]   = {prev_q[Q_W-2:0], 1'b1};
         end else begin
            dv_rem_in[j] = prev_rem;
            dv_q_in[j]   = {prev_q[Q_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      qv   = dv_q_ff[Q_W-1][S_W-1:0];
      snew = dv_neg_ff[Q_W-1]
           ? $signed({2'b00, dv_s_ff[Q_W-1]}) + $signed({2'b00, qv})
           : $signed({2'b00, dv_s_ff[Q_W-1]}) - $signed({2'b00, qv});
      if (dv_dz_ff[Q_W-1]) begin
         s5_in = dv_s_ff[Q_W-1];
      end else if (dv_q_ff[Q_W-1][Q_W-1]) begin
         s5_in = dv_neg_ff[Q_W-1] ? ONE_FX : '0;
      end else if (snew < 0) begin
         s5_in = '0;
      end else if (snew > $signed({2'b00, ONE_FX})) begin
         s5_in = ONE_FX;
      end else begin
         s5_in = snew[S_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         for (int j = 0; j < Q_W; j++) begin
            dv_v_ff[j] <= 1'b0;
         end
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         dv_v_ff[0] <= v4_ff;
         for (int j = 1; j < Q_W; j++) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         v5_ff <= dv_v_ff[Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff     <= in_s;
         t1_ff     <= in_t;
         s2_1_ff   <= s2_1_in;
         f1s_1_ff  <= f1s_1_in;
         f2s_1_ff  <= f2s_1_in;

         s_2_ff    <= s1_ff;
         t_2_ff    <= t1_ff;
         s3_2_ff   <= s3_2_in;
         f0s2_2_ff <= f0s2_2_in;
         f1s2_2_ff <= f1s2_2_in;
         f1s_2_ff  <= f1s_1_ff;
         f2s_2_ff  <= f2s_1_ff;

         s_3_ff    <= s_2_ff;
         t_3_ff    <= t_2_ff;
         f0s3_3_ff <= f0s3_3_in;
         f1s2_3_ff <= f1s2_2_ff;
         f2s_3_ff  <= f2s_2_ff;
         d_3_ff    <= d_3_in;

         s_4_ff    <= s_3_ff;
         t_4_ff    <= t_3_ff;
         xm_4_ff   <= xm_4_in;
         dm_4_ff   <= dm_4_in;
         neg_4_ff  <= neg_4_in;
         dz_4_ff   <= dz_4_in;

         dv_s_ff[0]   <= s_4_ff;
         dv_t_ff[0]   <= t_4_ff;
         dv_dm_ff[0]  <= dm_4_ff;
         dv_neg_ff[0] <= neg_4_ff;
         dv_dz_ff[0]  <= dz_4_ff;
         for (int j = 1; j < Q_W; j++) begin
            dv_s_ff[j]   <= dv_s_ff[j-1];
            dv_t_ff[j]   <= dv_t_ff[j-1];
            dv_dm_ff[j]  <= dv_dm_ff[j-1];
            dv_neg_ff[j] <= dv_neg_ff[j-1];
            dv_dz_ff[j]  <= dv_dz_ff[j-1];
         end
         for (int j = 0; j < Q_W; j++) begin
            dv_rem_ff[j] <= dv_rem_in[j];
            dv_q_ff[j]   <= dv_q_in[j];
         end

         s5_ff <= s5_in;
         t5_ff <= dv_t_ff[Q_W-1];
      end
   end

   assign out_valid = v5_ff;
   assign out_s     = s5_ff;
   assign out_t     = t5_ff;

endmodule

@@ rtl/cubic_bezier_easing_top.sv @@
// Cubic Bezier easing curve: Newton search for the parameter, then y.
// Each of the NEWTON_STEPS steps is a 4 stage polynomial pipeline, an
// 18 stage bit-per-stage divider and a clamp.
// Throughput is one request per cycle; the whole pipeline holds while a
// finished result is not taken. Reset (synchronous) clears all valid bits
// and sets the control points to (0, 0) and (1, 1).
// Depends on cbe_pkg, cbe_newton and cubic_bezier_easing_top_assert.svh.
`include "cubic_bezier_easing_top_assert.svh"

module cubic_bezier_easing_top import cbe_pkg::*; #(
   parameter int unsigned NEWTON_STEPS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [16:0] time_in, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [18:0] eased_value, rest zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_data
);

   typedef enum logic [2:0] {
      CSR_A_X = 3'd0,
      CSR_A_Y = 3'd1,
      CSR_B_X = 3'd2,
      CSR_B_Y = 3'd3
   } csr_idx_type;

   localparam int YP_W  = 21;
   localparam int SUM_W = 24;

   logic                   en;
   logic [CX_W-1:0]        ax_ff, bx_ff;
   logic signed [CY_W-1:0] ay_ff, by_ff;
   coef_type               coef_ff, coef_in;
   logic signed [F1_W:0]   ax3, bx3;

   logic                   in_valid_ff;
   logic [S_W-1:0]         t_ff, t_in;

   logic                   step_valid [NEWTON_STEPS+1];
   logic [S_W-1:0]         step_s     [NEWTON_STEPS+1];
   logic [S_W-1:0]         step_t     [NEWTON_STEPS+1];

   logic                   y1_valid_ff, y2_valid_ff, y3_valid_ff, rsp_valid_ff;
   logic [S_W-1:0]         u_y;
   logic [2*S_W-1:0]       puu, pus, pss, puus, puss, psss;
   logic [S_W-1:0]         s_y1_ff, uu_ff, us_ff, ss_ff;
   logic [S_W-1:0]         uus_ff, uss_ff, sss_ff, sss_y3_ff;
   logic signed [S_W+CY_W:0] pa, pb;
   logic signed [YP_W-1:0] ya_ff, yb_ff;
   logic signed [SUM_W-1:0] ysum;
   logic [CY_W-1:0]        rsp_data_ff, rsp_data_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en && !reset;
   assign csr_ready  = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         ay_ff <= '0;
         bx_ff <= CX_W'(ONE_FX);
         by_ff <= CY_W'(ONE_FX);
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_A_X: ax_ff <= csr_data[CX_W-1:0];
            CSR_A_Y: ay_ff <= csr_data;
            CSR_B_X: bx_ff <= csr_data[CX_W-1:0];
            CSR_B_Y: by_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Polynomial coefficients are registered from the control points and follow them in the next cycle.
   always_comb begin
      ax3        = $signed({1'b0, ax_ff, 1'b0}) + $signed({2'b00, ax_ff});
      bx3        = $signed({1'b0, bx_ff, 1'b0}) + $signed({2'b00, bx_ff});
      coef_in.f0 = F0_W'($signed({1'b0, ONE_FX}) - bx3 + ax3);
      coef_in.f1 = F1_W'(bx3 - (ax3 <<< 1));
      coef_in.f2 = F2_W'(ax3);
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   assign t_in = (req_tdata[S_W-1:0] > ONE_FX) ? ONE_FX : req_tdata[S_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff <= t_in;
      end
   end

   assign step_valid[0] = in_valid_ff;
   assign step_s[0]     = t_ff;
   assign step_t[0]     = t_ff;

   for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_step
      cbe_newton u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .coef      (coef_ff),
         .in_valid  (step_valid[g]),
         .in_s      (step_s[g]),
         .in_t      (step_t[g]),
         .out_valid (step_valid[g+1]),
         .out_s     (step_s[g+1]),
         .out_t     (step_t[g+1])
      );
   end

   // y(s) = 3(1-s)^2 s ay + 3(1-s) s^2 by + s^3, every product floored
   always_comb begin
      u_y  = ONE_FX - step_s[NEWTON_STEPS];
      puu  = u_y * u_y;
      pus  = u_y * step_s[NEWTON_STEPS];
      pss  = step_s[NEWTON_STEPS] * step_s[NEWTON_STEPS];
      puus = uu_ff * s_y1_ff;
      puss = us_ff * s_y1_ff;
      psss = ss_ff * s_y1_ff;
      pa   = $signed({1'b0, uus_ff}) * ay_ff;
      pb   = $signed({1'b0, uss_ff}) * by_ff;
      ysum = (SUM_W'(ya_ff) <<< 1) + SUM_W'(ya_ff)
           + (SUM_W'(yb_ff) <<< 1) + SUM_W'(yb_ff)
           + $signed({{(SUM_W-S_W){1'b0}}, sss_y3_ff});
      if (ysum < -(SUM_W'(1) <<< (CY_W - 1))) begin
         rsp_data_in = {1'b1, {(CY_W-1){1'b0}}};
      end else if (ysum > (SUM_W'(1) <<< (CY_W - 1)) - SUM_W'(1)) begin
         rsp_data_in = {1'b0, {(CY_W-1){1'b1}}};
      end else begin
         rsp_data_in = ysum[CY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_valid_ff  <= 1'b0;
         y2_valid_ff  <= 1'b0;
         y3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         y1_valid_ff  <= step_valid[NEWTON_STEPS];
         y2_valid_ff  <= y1_valid_ff;
         y3_valid_ff  <= y2_valid_ff;
         rsp_valid_ff <= y3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_y1_ff     <= step_s[NEWTON_STEPS];
         uu_ff       <= puu[FRAC_BITS +: S_W];
         us_ff       <= pus[FRAC_BITS +: S_W];
         ss_ff       <= pss[FRAC_BITS +: S_W];
         uus_ff      <= puus[FRAC_BITS +: S_W];
         uss_ff      <= puss[FRAC_BITS +: S_W];
         sss_ff      <= psss[FRAC_BITS +: S_W];
         ya_ff       <= pa[FRAC_BITS +: YP_W];
         yb_ff       <= pb[FRAC_BITS +: YP_W];
         sss_y3_ff   <= sss_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-CY_W){1'b0}}, rsp_data_ff};

   `CBE_ASSERT_IMP(a_time_clamped, clock, reset, in_valid_ff, t_ff <= ONE_FX, "time above one entered the search")
   `CBE_ASSERT_IMP(a_param_range, clock, reset, step_valid[NEWTON_STEPS], step_s[NEWTON_STEPS] <= ONE_FX, "curve parameter left [0, 1]")
   `CBE_ASSERT_NXT(a_stall_holds, clock, reset, !en, $stable(y3_valid_ff) && $stable(step_valid[NEWTON_STEPS]), "pipeline moved while stalled")

endmodule
